// ===== rtl/ffca_pkg.sv =====
`timescale 1ns / 1ps
package ffca_pkg;

	localparam int MAX_EXTENTS_DEF = 64;
	localparam logic [15:0] GROW_MIN_RESET = 16'd512;
	localparam logic [23:0] M24 = 24'hFFFFFF;

	// register indexes
	localparam logic [1:0] REG_HEAP_START = 2'd0;
	localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;
	localparam logic [1:0] REG_GROW_MIN = 2'd2;

	// action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	// status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_OOM = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic        action;
		logic [27:0] request_bytes;
		logic [23:0] payload_unit;
		logic [23:0] block_units;
	} in_t;

	typedef struct packed {
		logic [23:0] granted_unit;
		logic [23:0] granted_units;
		logic [1:0]  status;
	} out_t;

	// one free extent held by a cell
	typedef struct packed {
		logic        valid;
		logic [23:0] base;
		logic [23:0] len;
	} ent_t;

	// operands broadcast to every cell
	typedef struct packed {
		logic [23:0] h;
		logic [23:0] n;
		logic [28:0] units;
	} opnd_t;

	// registered per-cell evaluation flags
	typedef struct packed {
		logic        lt;
		logic        jprev;
		logic        jnext;
		logic        fit;
		logic        exact;
		logic [23:0] blk;
	} flag_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LEFT,
		OP_RIGHT,
		OP_LOAD,
		OP_ADDN,
		OP_ADDNX,
		OP_SETN,
		OP_SUB
	} cell_op_t;

	function automatic logic [23:0] sat24(input logic [25:0] v);
		sat24 = (v > {2'b00, M24}) ? M24 : v[23:0];
	endfunction

endpackage

// ===== rtl/ffca_cell.sv =====
`timescale 1ns / 1ps
module ffca_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ffca_pkg::cell_op_t op,
	input  ffca_pkg::opnd_t   opnd,
	input  ffca_pkg::ent_t    left,
	input  ffca_pkg::ent_t    right,
	input  logic              left_lt,
	input  logic              right_lt,
	output ffca_pkg::ent_t    ent,
	output logic              lt,
	output ffca_pkg::flag_t   flags
);

	logic        valid_q;
	logic [23:0] base_q;
	logic [23:0] len_q;
	ffca_pkg::flag_t flags_q;
	ffca_pkg::flag_t flags_d;

	assign ent = '{valid: valid_q, base: base_q, len: len_q};
	assign lt = valid_q && (base_q < opnd.h);

	// local evaluation against the broadcast operands
	always_comb begin
		flags_d.lt = lt;
		flags_d.jprev = lt && !right_lt &&
			(({1'b0, base_q} + {1'b0, len_q}) == {1'b0, opnd.h});
		flags_d.jnext = valid_q && !lt && left_lt &&
			(({1'b0, opnd.h} + {1'b0, opnd.n}) == {1'b0, base_q});
		flags_d.fit = valid_q && ({5'b0, len_q} >= opnd.units);
		flags_d.exact = valid_q && ({5'b0, len_q} == opnd.units);
		flags_d.blk = flags_d.exact ? base_q : (base_q + len_q - opnd.units[23:0]);
	end

	always_ff @(posedge clk) begin
		flags_q <= flags_d;
	end
	assign flags = flags_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				ffca_pkg::OP_LEFT:  valid_q <= right.valid;
				ffca_pkg::OP_RIGHT: valid_q <= left.valid;
				ffca_pkg::OP_LOAD:  valid_q <= 1'b1;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	// extent payload
	always_ff @(posedge clk) begin
		case (op)
			ffca_pkg::OP_LEFT: begin
				base_q <= right.base;
				len_q <= right.len;
			end
			ffca_pkg::OP_RIGHT: begin
				base_q <= left.base;
				len_q <= left.len;
			end
			ffca_pkg::OP_LOAD: begin
				base_q <= opnd.h;
				len_q <= opnd.n;
			end
			ffca_pkg::OP_ADDN: begin
				len_q <= ffca_pkg::sat24({2'b00, len_q} + {2'b00, opnd.n});
			end
			ffca_pkg::OP_ADDNX: begin
				len_q <= ffca_pkg::sat24({2'b00, len_q} + {2'b00, opnd.n} +
					{2'b00, right.len});
			end
			ffca_pkg::OP_SETN: begin
				base_q <= opnd.h;
				len_q <= ffca_pkg::sat24({2'b00, len_q} + {2'b00, opnd.n});
			end
			ffca_pkg::OP_SUB: begin
				len_q <= len_q - opnd.units[23:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/first_fit_coalescing_allocator_top.sv =====
// first-fit extent allocator built as a sorted chain of extent cells
// free: evaluate, then insert or merge, then result (null or zero-size free: straight to the result)
// allocate with a fit, or out of memory at the first search: evaluate, act on the search, then result
// allocate that grows the heap: search, insert, search again; result after the insert if table full
// one request at a time: next request taken the cycle after the result leaves
// reset: table empty, heap_top = 0, no clearing pass
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_top #(
	parameter int MAX_EXTENTS = ffca_pkg::MAX_EXTENTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffca_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ffca_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [23:0]     cfg_data
);

	localparam int N = MAX_EXTENTS;
	localparam int CW = $clog2(N + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEVAL,
		S_SACT,
		S_IEVAL,
		S_IACT,
		S_RESP
	} state_t;

	state_t state_q;
	logic [23:0] heap_limit_q, heap_top_q;
	logic [15:0] grow_min_q;
	logic [CW-1:0] cnt_q;
	logic growing_q, second_q;
	ffca_pkg::opnd_t opnd_q;
	ffca_pkg::out_t out_q;
	logic out_valid_q;

	ffca_pkg::cell_op_t ops [N];
	ffca_pkg::ent_t ents [N];
	ffca_pkg::flag_t flg [N];
	logic [N-1:0] lt_c, lt_v, jp_v, jn_v, fit_v, ex_v;

	// cell chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		ffca_pkg::ent_t lft, rgt;
		logic llt, rlt;
		if (i == 0) begin : g_first
			assign lft = '0;
			assign llt = 1'b1;
		end else begin : g_mid_l
			assign lft = ents[i-1];
			assign llt = lt_c[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rgt = '0;
			assign rlt = 1'b0;
		end else begin : g_mid_r
			assign rgt = ents[i+1];
			assign rlt = lt_c[i+1];
		end
		ffca_cell u_cell (
			.clk(clk), .arst_n(arst_n), .op(ops[i]), .opnd(opnd_q),
			.left(lft), .right(rgt), .left_lt(llt), .right_lt(rlt),
			.ent(ents[i]), .lt(lt_c[i]), .flags(flg[i])
		);
		assign lt_v[i] = flg[i].lt;
		assign jp_v[i] = flg[i].jprev;
		assign jn_v[i] = flg[i].jnext;
		assign fit_v[i] = flg[i].fit;
		assign ex_v[i] = flg[i].exact;
	end

	// first fit selection and insert position
	logic [N-1:0] sel, ge, first;
	logic found, exact;
	logic [23:0] blk;
	logic jp, jn, full;

	always_comb begin
		sel = fit_v & (~fit_v + N'(1));
		ge = ~(sel - N'(1));
		found = |fit_v;
		exact = |(sel & ex_v);
		blk = '0;
		for (int i = 0; i < N; i++) begin
			blk = blk | (sel[i] ? flg[i].blk : 24'd0);
		end
		first = ~lt_v & {lt_v[N-2:0], 1'b1};
		jp = |jp_v;
		jn = |jn_v;
		full = (cnt_q == CW'(N));
	end

	// per-cell commands
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ops[i] = ffca_pkg::OP_HOLD;
			if (state_q == S_SACT && found) begin
				if (exact) begin
					if (ge[i]) ops[i] = ffca_pkg::OP_LEFT;
				end else if (sel[i]) begin
					ops[i] = ffca_pkg::OP_SUB;
				end
			end else if (state_q == S_IACT) begin
				if (jp && jn) begin
					if (jp_v[i]) ops[i] = ffca_pkg::OP_ADDNX;
					else if (!lt_v[i]) ops[i] = ffca_pkg::OP_LEFT;
				end else if (jp) begin
					if (jp_v[i]) ops[i] = ffca_pkg::OP_ADDN;
				end else if (jn) begin
					if (jn_v[i]) ops[i] = ffca_pkg::OP_SETN;
				end else if (!full) begin
					if (first[i]) ops[i] = ffca_pkg::OP_LOAD;
					else if (!lt_v[i]) ops[i] = ffca_pkg::OP_RIGHT;
				end
			end
		end
	end

	// growth amount and limit check
	logic [28:0] grow;
	logic [29:0] top_sum;
	logic oom;
	always_comb begin
		grow = (opnd_q.units > {13'b0, grow_min_q}) ? opnd_q.units : {13'b0, grow_min_q};
		top_sum = {6'b0, heap_top_q} + {1'b0, grow};
		oom = (opnd_q.units[28:24] != 5'd0) || (top_sum > {6'b0, heap_limit_q});
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// control sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_limit_q <= ffca_pkg::M24;
			grow_min_q <= ffca_pkg::GROW_MIN_RESET;
			heap_top_q <= '0;
			cnt_q <= '0;
			growing_q <= 1'b0;
			second_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			opnd_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ffca_pkg::REG_HEAP_START: heap_top_q <= cfg_data;
					ffca_pkg::REG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					ffca_pkg::REG_GROW_MIN: grow_min_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						out_q <= '0;
						growing_q <= 1'b0;
						second_q <= 1'b0;
						if (in_data.action == ffca_pkg::ACT_FREE) begin
							opnd_q.h <= in_data.payload_unit - 24'd1;
							opnd_q.n <= in_data.block_units;
							if (in_data.payload_unit == 24'd0 || in_data.block_units == 24'd0) begin
								out_valid_q <= 1'b1;
								state_q <= S_RESP;
							end else begin
								state_q <= S_IEVAL;
							end
						end else begin
							opnd_q.units <= {1'b0, 4'b0, in_data.request_bytes[27:4]} +
								29'(|in_data.request_bytes[3:0]) + 29'd1;
							state_q <= S_SEVAL;
						end
					end
				end
				S_SEVAL: state_q <= S_SACT;
				S_SACT: begin
					if (found) begin
						if (exact) cnt_q <= cnt_q - CW'(1);
						out_q.granted_unit <= blk + 24'd1;
						out_q.granted_units <= opnd_q.units[23:0];
						out_q.status <= ffca_pkg::STAT_OK;
						out_valid_q <= 1'b1;
						state_q <= S_RESP;
					end else if (second_q || oom) begin
						out_q.status <= ffca_pkg::STAT_OOM;
						out_valid_q <= 1'b1;
						state_q <= S_RESP;
					end else begin
						opnd_q.h <= heap_top_q;
						opnd_q.n <= grow[23:0];
						growing_q <= 1'b1;
						state_q <= S_IEVAL;
					end
				end
				S_IEVAL: state_q <= S_IACT;
				S_IACT: begin
					if (!jp && !jn && full) begin
						out_q.status <= ffca_pkg::STAT_FULL;
						out_valid_q <= 1'b1;
						state_q <= S_RESP;
					end else begin
						if (jp && jn) cnt_q <= cnt_q - CW'(1);
						else if (!jp && !jn) cnt_q <= cnt_q + CW'(1);
						if (growing_q) begin
							heap_top_q <= heap_top_q + opnd_q.n;
							growing_q <= 1'b0;
							second_q <= 1'b1;
							state_q <= S_SEVAL;
						end else begin
							out_q.status <= ffca_pkg::STAT_OK;
							out_valid_q <= 1'b1;
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
